// ===== rtl/core/cxdna_pkg.sv =====
package cxdna_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_LAST
    } state_t;

    localparam logic [2:0] CFG_SEED_KEYSTREAM = 3'd0;
    localparam logic [2:0] CFG_GAIN_KEYSTREAM = 3'd1;
    localparam logic [2:0] CFG_SEED_RULE_A    = 3'd2;
    localparam logic [2:0] CFG_SEED_RULE_B    = 3'd3;
    localparam logic [2:0] CFG_GAIN_RULES     = 3'd4;

    localparam logic [1:0] MAP_KEYSTREAM = 2'd0;
    localparam logic [1:0] MAP_RULE_A    = 2'd1;
    localparam logic [1:0] MAP_RULE_B    = 2'd2;

    localparam logic [1:0] PH_SQUARE = 2'd0;
    localparam logic [1:0] PH_GAIN   = 2'd1;
    localparam logic [1:0] PH_QUANT  = 2'd2;

    localparam logic [31:0] QUANT_SCALE = 32'd10000;

    typedef struct packed {
        logic        en;
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    localparam logic [1:0] ENC_RULE [8][4] = '{
        '{2'd0, 2'd3, 2'd2, 2'd1}, '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd1, 2'd3, 2'd2, 2'd0}, '{2'd1, 2'd2, 2'd3, 2'd0},
        '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd2, 2'd1, 2'd0, 2'd3}, '{2'd3, 2'd1, 2'd0, 2'd2}
    };

    localparam logic [1:0] DEC_RULE [8][4] = '{
        '{2'd0, 2'd3, 2'd2, 2'd1}, '{2'd0, 2'd3, 2'd1, 2'd2},
        '{2'd3, 2'd0, 2'd2, 2'd1}, '{2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd1, 2'd2, 2'd0, 2'd3}, '{2'd1, 2'd2, 2'd3, 2'd0},
        '{2'd2, 2'd1, 2'd0, 2'd3}, '{2'd2, 2'd1, 2'd3, 2'd0}
    };

    function automatic logic [7:0] dna_substitute(input logic [7:0] value,
                                                  input logic [2:0] enc_key,
                                                  input logic [2:0] dec_key);
        logic [7:0] res;
        logic [1:0] e;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            e = ENC_RULE[enc_key][value[2*k +: 2]];
            res[2*k +: 2] = DEC_RULE[dec_key][e];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/cxdna_mul.sv =====
module cxdna_mul (
    input  logic                aclk,
    input  cxdna_pkg::mul_req_t req,
    output logic [63:0]         prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= 64'(req.a) * 64'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/chaotic_xor_dna_pixel_cipher_core.sv =====
// Channel   Direction  Ports                          Contents
// s_        in         s_tvalid s_tready s_tdata      pixel; s_tuser: first
// m_        out        m_tvalid m_tready m_tdata      cipher_pixel
// cfg_      in         cfg_valid cfg_ready            cfg_index, cfg_data
//
// A new pixel is taken only once the result of the last one is registered;
// the one shared 32 by 32 multiplier forms nine products per pixel, three
// for each logistic map.
// Reset clears the map states and restores the register defaults.
// A result that waits on m_tready holds the block in its final cycle only;
// the next pixel is taken as soon as the result is registered.
module chaotic_xor_dna_pixel_cipher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pixel
    input  logic [0:0]  s_tuser,    // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] cipher_pixel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cxdna_pkg::state_t   state_reg, state_next;
    cxdna_pkg::mul_req_t mul_req;
    logic [63:0]         prod;

    logic [31:0] seed_ks_reg, gain_ks_reg, seed_a_reg, seed_b_reg, gain_rules_reg;
    logic [31:0] x_ks_reg, x_a_reg, x_b_reg;
    logic [31:0] x_ks_next, x_a_next, x_b_next;
    logic [1:0]  map_reg, map_next, phase_reg, phase_next;
    logic [7:0]  pixel_reg, ks_reg, ks_next;
    logic [2:0]  ka_reg, ka_next;
    logic [7:0]  cipher_reg, cipher_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] x_sel, gain_sel, x_new;
    logic [7:0]  quant;
    logic        s_xfer, m_free;

    assign s_tready  = (state_reg == cxdna_pkg::ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = cipher_reg;
    assign m_free    = !m_tvalid_reg || m_tready;

    assign x_new = prod[61:30];
    assign quant = prod[39:32] + {7'b0, prod[31]};

    always_comb begin
        unique case (map_reg)
            cxdna_pkg::MAP_KEYSTREAM: begin
                x_sel    = x_ks_reg;
                gain_sel = gain_ks_reg;
            end
            cxdna_pkg::MAP_RULE_A: begin
                x_sel    = x_a_reg;
                gain_sel = gain_rules_reg;
            end
            default: begin
                x_sel    = x_b_reg;
                gain_sel = gain_rules_reg;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cxdna_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = cxdna_pkg::ST_CALC;
                end
            end
            cxdna_pkg::ST_CALC: begin
                if (phase_reg == cxdna_pkg::PH_QUANT && map_reg == cxdna_pkg::MAP_RULE_B) begin
                    state_next = cxdna_pkg::ST_LAST;
                end
            end
            cxdna_pkg::ST_LAST: begin
                if (m_free) begin
                    state_next = cxdna_pkg::ST_IDLE;
                end
            end
            default: state_next = cxdna_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mul_req       = '0;
        x_ks_next     = x_ks_reg;
        x_a_next      = x_a_reg;
        x_b_next      = x_b_reg;
        map_next      = map_reg;
        phase_next    = phase_reg;
        ks_next       = ks_reg;
        ka_next       = ka_reg;
        cipher_next   = cipher_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            cxdna_pkg::ST_IDLE: begin
                map_next   = cxdna_pkg::MAP_KEYSTREAM;
                phase_next = cxdna_pkg::PH_SQUARE;
                if (s_xfer && s_tuser[0]) begin
                    x_ks_next = seed_ks_reg;
                    x_a_next  = seed_a_reg;
                    x_b_next  = seed_b_reg;
                end
            end
            cxdna_pkg::ST_CALC: begin
                mul_req.en = 1'b1;
                unique case (phase_reg)
                    cxdna_pkg::PH_SQUARE: begin
                        mul_req.a  = x_sel;
                        mul_req.b  = 32'd0 - x_sel;
                        phase_next = cxdna_pkg::PH_GAIN;
                        if (map_reg == cxdna_pkg::MAP_RULE_A) begin
                            ks_next = quant;
                        end
                        if (map_reg == cxdna_pkg::MAP_RULE_B) begin
                            ka_next = quant[2:0];
                        end
                    end
                    cxdna_pkg::PH_GAIN: begin
                        mul_req.a  = gain_sel;
                        mul_req.b  = prod[63:32];
                        phase_next = cxdna_pkg::PH_QUANT;
                    end
                    default: begin
                        mul_req.a  = x_new;
                        mul_req.b  = cxdna_pkg::QUANT_SCALE;
                        phase_next = cxdna_pkg::PH_SQUARE;
                        if (map_reg == cxdna_pkg::MAP_RULE_B) begin
                            map_next = cxdna_pkg::MAP_KEYSTREAM;
                        end else begin
                            map_next = map_reg + 2'd1;
                        end
                        unique case (map_reg)
                            cxdna_pkg::MAP_KEYSTREAM: x_ks_next = x_new;
                            cxdna_pkg::MAP_RULE_A:    x_a_next  = x_new;
                            default:                  x_b_next  = x_new;
                        endcase
                    end
                endcase
            end
            cxdna_pkg::ST_LAST: begin
                if (m_free) begin
                    cipher_next   = cxdna_pkg::dna_substitute(pixel_reg ^ ks_reg, ka_reg,
                                                              quant[2:0]);
                    m_tvalid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    cxdna_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cxdna_pkg::ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            map_reg        <= cxdna_pkg::MAP_KEYSTREAM;
            phase_reg      <= cxdna_pkg::PH_SQUARE;
            x_ks_reg       <= '0;
            x_a_reg        <= '0;
            x_b_reg        <= '0;
            seed_ks_reg    <= 32'd2147483648;
            gain_ks_reg    <= 32'd4294859922;
            seed_a_reg     <= 32'd2147483648;
            seed_b_reg     <= 32'd996432413;
            gain_rules_reg <= 32'd4187485739;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            map_reg      <= map_next;
            phase_reg    <= phase_next;
            x_ks_reg     <= x_ks_next;
            x_a_reg      <= x_a_next;
            x_b_reg      <= x_b_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    cxdna_pkg::CFG_SEED_KEYSTREAM: seed_ks_reg    <= cfg_data;
                    cxdna_pkg::CFG_GAIN_KEYSTREAM: gain_ks_reg    <= cfg_data;
                    cxdna_pkg::CFG_SEED_RULE_A:    seed_a_reg     <= cfg_data;
                    cxdna_pkg::CFG_SEED_RULE_B:    seed_b_reg     <= cfg_data;
                    cxdna_pkg::CFG_GAIN_RULES:     gain_rules_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pixel_reg <= s_tdata;
        end
        ks_reg     <= ks_next;
        ka_reg     <= ka_next;
        cipher_reg <= cipher_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == cxdna_pkg::ST_CALC && map_reg == cxdna_pkg::MAP_KEYSTREAM
                    && phase_reg == cxdna_pkg::PH_SQUARE))
        else $error("pixel transfer did not start the map sequence");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cxdna_pkg::ST_LAST && m_free) |=>
            (m_tvalid && state_reg == cxdna_pkg::ST_IDLE))
        else $error("finished pixel did not produce a result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (map_reg != 2'd3) && (phase_reg != 2'd3))
        else $error("sequencer counter out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cxdna_pkg::ST_LAST && !m_free) |=>
            (state_reg == cxdna_pkg::ST_LAST && $stable(prod)))
        else $error("stalled result lost its last product");

endmodule

// ===== verif/cipher_pixel_checker.sv =====
module cipher_pixel_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [7:0] plain;
        logic [7:0] cipher;
    } cipher_due_t;

    localparam logic [31:0] DEFAULT_SEED_KEYSTREAM = 32'h8000_0000;
    localparam logic [31:0] DEFAULT_GAIN_KEYSTREAM = 32'd4294859922;
    localparam logic [31:0] DEFAULT_SEED_RULE_A    = 32'h8000_0000;
    localparam logic [31:0] DEFAULT_SEED_RULE_B    = 32'd996432413;
    localparam logic [31:0] DEFAULT_GAIN_RULES     = 32'd4187485739;

    localparam logic [0:7][0:3][1:0] ENCODE_MAP = {
        {2'd0, 2'd3, 2'd2, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
        {2'd1, 2'd3, 2'd2, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
        {2'd2, 2'd0, 2'd1, 2'd3}, {2'd3, 2'd0, 2'd1, 2'd2},
        {2'd2, 2'd1, 2'd0, 2'd3}, {2'd3, 2'd1, 2'd0, 2'd2}
    };

    // Each decode rule is the inverse of the encode rule with the same key.
    localparam logic [0:7][0:3][1:0] DECODE_MAP = {
        {2'd0, 2'd3, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd1, 2'd2},
        {2'd3, 2'd0, 2'd2, 2'd1}, {2'd3, 2'd0, 2'd1, 2'd2},
        {2'd1, 2'd2, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd3, 2'd0},
        {2'd2, 2'd1, 2'd0, 2'd3}, {2'd2, 2'd1, 2'd3, 2'd0}
    };

    logic [31:0] seed_keystream;
    logic [31:0] gain_keystream;
    logic [31:0] seed_rule_a;
    logic [31:0] seed_rule_b;
    logic [31:0] gain_rules;

    logic [31:0] keystream_x;
    logic [31:0] rule_a_x;
    logic [31:0] rule_b_x;

    cipher_due_t cipher_due[$];
    int          fail_count = 0;
    int          due_count  = 0;

    assign mismatches  = fail_count;
    assign outstanding = due_count;

    function automatic logic [31:0] logistic_next(input logic [31:0] x, input logic [31:0] g);
        logic [63:0] square;
        logic [63:0] scaled;
        square = {32'd0, x} * ((64'd1 << 32) - {32'd0, x});
        scaled = ({32'd0, g} * (square >> 32)) >> 30;
        return (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
    endfunction

    function automatic logic [31:0] times_ten_thousand(input logic [31:0] x);
        logic [63:0] wide;
        wide = {32'd0, x} * 64'd10000 + 64'h8000_0000;
        return wide[63:32];
    endfunction

    function automatic logic [7:0] dna_recode(input logic [7:0] value,
                                              input logic [2:0] enc_key,
                                              input logic [2:0] dec_key);
        logic [7:0] res;
        logic [1:0] base;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            base = ENCODE_MAP[enc_key][value[2*k +: 2]];
            res[2*k +: 2] = DECODE_MAP[dec_key][base];
        end
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        cipher_due_t due;
        logic [31:0] stream_q;
        logic [31:0] key_a_q;
        logic [31:0] key_b_q;
        if (!aresetn) begin
            seed_keystream = DEFAULT_SEED_KEYSTREAM;
            gain_keystream = DEFAULT_GAIN_KEYSTREAM;
            seed_rule_a    = DEFAULT_SEED_RULE_A;
            seed_rule_b    = DEFAULT_SEED_RULE_B;
            gain_rules     = DEFAULT_GAIN_RULES;
            keystream_x    = '0;
            rule_a_x       = '0;
            rule_b_x       = '0;
            cipher_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    cxdna_pkg::CFG_SEED_KEYSTREAM: seed_keystream = cfg_data;
                    cxdna_pkg::CFG_GAIN_KEYSTREAM: gain_keystream = cfg_data;
                    cxdna_pkg::CFG_SEED_RULE_A:    seed_rule_a    = cfg_data;
                    cxdna_pkg::CFG_SEED_RULE_B:    seed_rule_b    = cfg_data;
                    cxdna_pkg::CFG_GAIN_RULES:     gain_rules     = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (cipher_due.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("cipher pixel %02h arrived with no pixel outstanding", m_tdata);
                    end
                    fail_count = fail_count + 1;
                end else begin
                    due = cipher_due.pop_front();
                    if (m_tdata !== due.cipher) begin
                        if (fail_count < 10) begin
                            $display("plain pixel %02h: expected cipher %02h, got %02h",
                                     due.plain, due.cipher, m_tdata);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0]) begin
                    keystream_x = seed_keystream;
                    rule_a_x    = seed_rule_a;
                    rule_b_x    = seed_rule_b;
                end
                keystream_x = logistic_next(keystream_x, gain_keystream);
                rule_a_x    = logistic_next(rule_a_x, gain_rules);
                rule_b_x    = logistic_next(rule_b_x, gain_rules);
                stream_q    = times_ten_thousand(keystream_x);
                key_a_q     = times_ten_thousand(rule_a_x);
                key_b_q     = times_ten_thousand(rule_b_x);
                due.plain   = s_tdata;
                due.cipher  = dna_recode(s_tdata ^ stream_q[7:0], key_a_q[2:0], key_b_q[2:0]);
                cipher_due.push_back(due);
            end
        end
        due_count <= cipher_due.size();
    end

endmodule

// ===== verif/tb_chaotic_xor_dna_pixel_cipher_core.sv =====
module tb_chaotic_xor_dna_pixel_cipher_core;

    localparam int PHASE_COUNT      = 8;
    localparam int PIXELS_PER_PHASE = 66;
    localparam int HOLD_AFTER       = 100;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 20;

    localparam logic [2:0] CFG_UNUSED = 3'd5;

    localparam logic [31:0] DEFAULT_SEED_KEYSTREAM = 32'h8000_0000;
    localparam logic [31:0] DEFAULT_GAIN_KEYSTREAM = 32'd4294859922;
    localparam logic [31:0] DEFAULT_SEED_RULE_A    = 32'h8000_0000;
    localparam logic [31:0] DEFAULT_SEED_RULE_B    = 32'd996432413;
    localparam logic [31:0] DEFAULT_GAIN_RULES     = 32'd4187485739;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        cfg_ready;
    int          mismatches;
    int          outstanding;
    int          pixels_taken = 0;

    chaotic_xor_dna_pixel_cipher_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cipher_pixel_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 50);
    endfunction

    function automatic logic [31:0] pick_seed();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Gains of 3.5 and above keep the maps chaotic; the rest may settle.
    function automatic logic [31:0] pick_gain();
        if ($urandom_range(0, 9) < 7) begin
            return 32'hE000_0000 | $urandom_range(0, 32'h1FFF_FFFF);
        end
        return $urandom();
    endfunction

    task automatic send_pixel(input logic [7:0] pixel, input logic first);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= pixel;
        s_tuser[0] <= first;
        do @(posedge aclk); while (!s_tready);
        pixels_taken = pixels_taken + 1;
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        int gap;
        gap = $urandom_range(0, 2);
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // A write to an index beyond the register file must leave every register alone.
    task automatic program_registers(input logic [31:0] seed_ks, input logic [31:0] gain_ks,
                                     input logic [31:0] seed_a, input logic [31:0] seed_b,
                                     input logic [31:0] gain_ab);
        write_register(cxdna_pkg::CFG_SEED_KEYSTREAM, seed_ks);
        write_register(cxdna_pkg::CFG_GAIN_KEYSTREAM, gain_ks);
        write_register(cxdna_pkg::CFG_SEED_RULE_A, seed_a);
        write_register(cxdna_pkg::CFG_SEED_RULE_B, seed_b);
        write_register(cxdna_pkg::CFG_GAIN_RULES, gain_ab);
        if ($urandom_range(0, 1) == 1) begin
            write_register(3'(CFG_UNUSED + $urandom_range(0, 2)), $urandom());
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin : receiver
        bit hold_done;
        int len;
        int r;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && pixels_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                len = HOLD_CYCLES;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_tready <= 1'b1;
                    len = $urandom_range(1, 8);
                end else if (r < 65) begin
                    m_tready <= 1'b1;
                    len = $urandom_range(20, 80);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    len = $urandom_range(20, 60);
                end
            end
            repeat (len) @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic first;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Before any first pixel the maps sit at zero.
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h5A, 1'b0);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h0F, 1'b0);
        send_pixel(8'hF0, 1'b1);
        send_pixel(8'h3C, 1'b0);

        wait_idle();
        program_registers('0, '0, '0, '0, '0);
        send_pixel(8'hC3, 1'b1);
        send_pixel(8'h96, 1'b0);

        wait_idle();
        program_registers('1, '1, '1, '1, '1);
        send_pixel(8'h81, 1'b1);
        send_pixel(8'h7E, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h80, 1'b0);

        wait_idle();
        program_registers(32'h0000_0001, '1, 32'h7FFF_FFFF, 32'h0000_0001, 32'hF000_0000);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h24, 1'b0);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_idle();
            if (ph == 0) begin
                program_registers(DEFAULT_SEED_KEYSTREAM, DEFAULT_GAIN_KEYSTREAM,
                                  DEFAULT_SEED_RULE_A, DEFAULT_SEED_RULE_B,
                                  DEFAULT_GAIN_RULES);
            end else begin
                program_registers(pick_seed(), pick_gain(), pick_seed(), pick_seed(),
                                  pick_gain());
            end
            for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
                if (i == 0) begin
                    first = ($urandom_range(0, 3) != 0);
                end else begin
                    first = ($urandom_range(0, 19) == 0);
                end
                send_pixel(8'($urandom_range(0, 255)), first);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cxdna_pkg.sv
rtl/core/cxdna_mul.sv
rtl/core/chaotic_xor_dna_pixel_cipher_core.sv
verif/cipher_pixel_checker.sv
verif/tb_chaotic_xor_dna_pixel_cipher_core.sv
